/* sv/trqs_pkg.sv */
// Shared codes for the thread ready-queue scheduler.
// Holds the operation and status encodings; depends on nothing.
package trqs_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_SCHED  = 2'd2,
    OP_EXIT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BADTARGET = 2'd1,
    ST_FULL      = 2'd2,
    ST_DONE      = 2'd3
  } status_e;

endpackage

/* sv/thread_ready_queue_scheduler_unit.sv */
// Thread scheduler with a FIFO ready queue kept as per-slot queue positions.
// Depends on trqs_pkg and trqs_ram.
// From accept to result: create runs a free-slot search, one entry a cycle; yield, schedule
// and exit do two entry reads, then a walk over every slot; an out-of-range target or no free
// slot goes straight to the result; an absent target or a schedule on an empty queue ends
// after the two reads. Reset: a clearing pass initialises the slot RAM; in_stall_o stays high.
// One item at a time: in_stall_o is high from accept until the result is loaded.
module thread_ready_queue_scheduler_unit #(
  parameter int THREAD_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  trqs_pkg::op_e     in_opcode_i,
  input  logic [7:0]        in_target_thread_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trqs_pkg::status_e out_status_o,
  output logic [2:0]        out_running_thread_o,
  output logic [2:0]        out_reported_thread_o
);
  import trqs_pkg::*;

  localparam int IW = $clog2(THREAD_SLOTS);
  localparam int PW = $clog2(THREAD_SLOTS + 1);
  localparam int EW = PW + 1;
  localparam logic [PW-1:0] NPOS = PW'(THREAD_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(THREAD_SLOTS - 1);

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] pos;
  } entry_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD1   = 7'b0000100,
    S_RD2   = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  // Control state
  state_e        state_q, state_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] last_q, last_d;
  logic [PW-1:0] vcount_q, vcount_d;
  logic [PW-1:0] qcount_q, qcount_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;

  // Item and walk payload
  op_e           op_q, op_d;
  logic [IW-1:0] tgt_q, tgt_d;
  entry_t        ent1_q, ent1_d;
  logic [IW-1:0] pend_addr_q, pend_addr_d;
  logic          search_q, search_d;
  logic [IW-1:0] self_q, self_d;
  logic          req_en_q, req_en_d;
  logic [PW-1:0] req_pos_q, req_pos_d;
  logic          rem_en_q, rem_en_d;
  logic [IW-1:0] rem_slot_q, rem_slot_d;
  logic [PW-1:0] rem_p_q, rem_p_d;
  logic          clr_en_q, clr_en_d;
  logic          pop_en_q, pop_en_d;
  logic [IW-1:0] head_q, head_d;
  status_e       res_status_q, res_status_d;
  logic [IW-1:0] res_run_q, res_run_d;
  logic [IW-1:0] res_rep_q, res_rep_d;
  status_e       out_status_q, out_status_d;
  logic [IW-1:0] out_run_q, out_run_d;
  logic [IW-1:0] out_rep_q, out_rep_d;

  // RAM ports
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  trqs_ram #(
    .WIDTH (EW),
    .DEPTH (THREAD_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  entry_t        rd_e;
  logic          accept;
  logic          tgt_ok;
  logic [IW-1:0] addr_nx;
  logic [IW-1:0] srch_start;

  assign rd_e       = entry_t'(ram_rdata);
  assign accept     = in_valid_i && !in_stall_o;
  assign tgt_ok     = {1'b0, in_target_thread_i} < 9'(THREAD_SLOTS);
  assign addr_nx    = (addr_q == LAST) ? '0 : addr_q + IW'(1);
  assign srch_start = (last_q == LAST) ? '0 : last_q + IW'(1);

  // Decision terms, evaluated while the running slot's entry sits on the read port
  logic          cur_req;
  logic [PW-1:0] qcount_req;
  logic [PW-1:0] yield_p;
  logic [PW-1:0] exit_qc;
  logic [PW-1:0] exit_vc;
  logic          exit_pop;

  assign cur_req    = rd_e.valid && (rd_e.pos == NPOS);
  assign qcount_req = qcount_q + PW'(cur_req);
  assign yield_p    = ((tgt_q == cur_q) && cur_req) ? qcount_q : ent1_q.pos;
  assign exit_qc    = qcount_q - PW'(rd_e.pos != NPOS);
  assign exit_vc    = vcount_q - PW'(rd_e.valid);
  assign exit_pop   = (exit_vc != '0) && (exit_qc != '0);

  // Per-entry update during a walk: requeue, remove, then pop head
  logic [PW-1:0] p0, p1, p2;
  logic          v1;
  logic          is_head;

  assign p0 = (req_en_q && (pend_addr_q == self_q)) ? req_pos_q : rd_e.pos;
  assign v1 = rd_e.valid && !(clr_en_q && (pend_addr_q == self_q));
  assign p1 = !rem_en_q ? p0 :
              (pend_addr_q == rem_slot_q) ? NPOS :
              ((p0 != NPOS) && (p0 > rem_p_q)) ? p0 - PW'(1) : p0;
  assign is_head = pop_en_q && (p1 == '0);
  assign p2 = !pop_en_q ? p1 :
              (p1 == '0) ? NPOS :
              (p1 != NPOS) ? p1 - PW'(1) : p1;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    last_d       = last_q;
    vcount_d     = vcount_q;
    qcount_d     = qcount_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    tgt_d        = tgt_q;
    ent1_d       = ent1_q;
    pend_addr_d  = addr_q;
    search_d     = search_q;
    self_d       = self_q;
    req_en_d     = req_en_q;
    req_pos_d    = req_pos_q;
    rem_en_d     = rem_en_q;
    rem_slot_d   = rem_slot_q;
    rem_p_d      = rem_p_q;
    clr_en_d     = clr_en_q;
    pop_en_d     = pop_en_q;
    head_d       = head_q;
    res_status_d = res_status_q;
    res_run_d    = res_run_q;
    res_rep_d    = res_rep_q;
    out_status_d = out_status_q;
    out_run_d    = out_run_q;
    out_rep_d    = out_rep_q;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = cur_q;

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = {(addr_q == '0), NPOS};
        addr_d    = addr_nx;
        if (addr_q == LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_d     = in_opcode_i;
          tgt_d    = in_target_thread_i[IW-1:0];
          search_d = 1'b0;
          req_en_d = 1'b0;
          rem_en_d = 1'b0;
          clr_en_d = 1'b0;
          pop_en_d = 1'b0;
          self_d   = cur_q;
          head_d   = cur_q;
          cnt_d    = '0;
          addr_d   = '0;
          unique case (in_opcode_i)
            OP_CREATE: begin
              if (vcount_q == NPOS) begin
                res_status_d = ST_FULL;
                res_run_d    = cur_q;
                res_rep_d    = '0;
                state_d      = S_OUT;
              end else begin
                search_d = 1'b1;
                addr_d   = srch_start;
                state_d  = S_WALK;
              end
            end
            OP_YIELD: begin
              if (!tgt_ok) begin
                res_status_d = ST_BADTARGET;
                res_run_d    = cur_q;
                res_rep_d    = '0;
                state_d      = S_OUT;
              end else begin
                state_d = S_RD1;
              end
            end
            default: begin
              state_d = S_RD1;
            end
          endcase
        end
      end

      S_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = (op_q == OP_YIELD) ? tgt_q : cur_q;
        state_d   = S_RD2;
      end

      S_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = cur_q;
        ent1_d    = rd_e;
        state_d   = S_DEC;
      end

      S_DEC: begin
        res_rep_d = cur_q;
        state_d   = S_WALK;
        unique case (op_q)
          OP_YIELD: begin
            if (!ent1_q.valid) begin
              res_status_d = ST_BADTARGET;
              res_run_d    = cur_q;
              res_rep_d    = '0;
              state_d      = S_OUT;
            end else begin
              req_en_d     = cur_req;
              req_pos_d    = qcount_q;
              rem_en_d     = 1'b1;
              rem_slot_d   = tgt_q;
              rem_p_d      = yield_p;
              qcount_d     = qcount_req - PW'(yield_p != NPOS);
              cur_d        = tgt_q;
              res_status_d = ST_OK;
              res_run_d    = tgt_q;
            end
          end
          OP_SCHED: begin
            if (qcount_req == '0) begin
              res_status_d = ST_DONE;
              res_run_d    = cur_q;
              state_d      = S_OUT;
            end else begin
              req_en_d     = cur_req;
              req_pos_d    = qcount_q;
              pop_en_d     = 1'b1;
              qcount_d     = qcount_req - PW'(1);
              res_status_d = ST_OK;
            end
          end
          OP_EXIT: begin
            clr_en_d     = 1'b1;
            rem_en_d     = 1'b1;
            rem_slot_d   = cur_q;
            rem_p_d      = rd_e.pos;
            pop_en_d     = exit_pop;
            vcount_d     = exit_vc;
            qcount_d     = exit_qc - PW'(exit_pop);
            res_status_d = exit_pop ? ST_OK : ST_DONE;
            res_run_d    = cur_q;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end

      S_WALK: begin
        // Issue the next read while the previous entry is written back
        if (cnt_q != NPOS) begin
          ram_re      = 1'b1;
          ram_raddr   = addr_q;
          pend_d      = 1'b1;
          pend_addr_d = addr_q;
          addr_d      = addr_nx;
          cnt_d       = cnt_q + PW'(1);
        end
        if (search_q) begin
          // First free slot found: claim it and append it to the queue
          if (pend_q && !rd_e.valid) begin
            ram_we       = 1'b1;
            ram_wdata    = {1'b1, (rd_e.pos == NPOS) ? qcount_q : rd_e.pos};
            qcount_d     = qcount_q + PW'(rd_e.pos == NPOS);
            vcount_d     = vcount_q + PW'(1);
            last_d       = pend_addr_q;
            res_status_d = ST_OK;
            res_run_d    = cur_q;
            res_rep_d    = pend_addr_q;
            state_d      = S_OUT;
          end
        end else begin
          if (pend_q) begin
            ram_we    = 1'b1;
            ram_wdata = {v1, p2};
            if (is_head) begin
              head_d = pend_addr_q;
            end
          end
          if ((cnt_q == NPOS) && !pend_q) begin
            if (pop_en_q) begin
              cur_d     = head_q;
              res_run_d = head_q;
            end
            state_d = S_OUT;
          end
        end
      end

      S_OUT: begin
        // Load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_run_d    = res_run_q;
          out_rep_d    = res_rep_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cur_q       <= '0;
      last_q      <= '0;
      vcount_q    <= PW'(1);
      qcount_q    <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      vcount_q    <= vcount_d;
      qcount_q    <= qcount_d;
      addr_q      <= addr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tgt_q        <= tgt_d;
    ent1_q       <= ent1_d;
    pend_addr_q  <= pend_addr_d;
    search_q     <= search_d;
    self_q       <= self_d;
    req_en_q     <= req_en_d;
    req_pos_q    <= req_pos_d;
    rem_en_q     <= rem_en_d;
    rem_slot_q   <= rem_slot_d;
    rem_p_q      <= rem_p_d;
    clr_en_q     <= clr_en_d;
    pop_en_q     <= pop_en_d;
    head_q       <= head_d;
    res_status_q <= res_status_d;
    res_run_q    <= res_run_d;
    res_rep_q    <= res_rep_d;
    out_status_q <= out_status_d;
    out_run_q    <= out_run_d;
    out_rep_q    <= out_rep_d;
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_status_q;
  assign out_running_thread_o  = 3'(out_run_q);
  assign out_reported_thread_o = 3'(out_rep_q);

endmodule

/* sv/trqs_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
module trqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/trqs_checker.sv */
// Port-level checks for the thread ready-queue scheduler, bound to the top level.
// Depends on trqs_pkg.
module trqs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input trqs_pkg::status_e out_status_o,
  input logic [2:0]        out_running_thread_o,
  input logic [2:0]        out_reported_thread_o
);
  import trqs_pkg::*;

  // One item at a time: an accept closes the input side
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item was in flight");

  // All-done keeps the exiting or idle slot as both running and reported
  a_done_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == ST_DONE)) |->
      (out_running_thread_o == out_reported_thread_o))
    else $error("all-done result with differing slots");

  // Failed operations report slot zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_status_o == ST_BADTARGET) || (out_status_o == ST_FULL))) |->
      (out_reported_thread_o == 3'd0))
    else $error("failed operation reported a non-zero slot");

  // A result waiting under stall holds its status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_status_o)))
    else $error("stalled result changed");

endmodule

bind thread_ready_queue_scheduler_unit trqs_checker u_trqs_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .out_status_o          (out_status_o),
  .out_running_thread_o  (out_running_thread_o),
  .out_reported_thread_o (out_reported_thread_o)
);
